// ===== sv/uart_line_receiver_unit_assert.svh =====
// Assertion macros shared by the receiver modules.
// Each expects i_clk and i_rst_n in scope.
`ifndef UART_LINE_RECEIVER_UNIT_ASSERT_SVH
`define UART_LINE_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ULR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ULR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ulr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ulr_pkg;

    localparam int DATA_BITS  = 8;
    localparam int BIT_IDX_W  = $clog2(DATA_BITS);
    localparam int BIT_CNT_W  = 4;
    localparam int IDLE_W     = 16;
    localparam int LINE_POS_W = 13;
    localparam int LINE_BYTES = 64;

    localparam logic [DATA_BITS-1:0] LINE_FEED      = 8'h0A;
    localparam logic [IDLE_W-1:0]    IDLE_MAX       = 16'hFFFF;
    localparam logic [IDLE_W-1:0]    MAX_IDLE_RESET = 16'd9600;

    // Character event from the frame decoder
    typedef struct packed {
        logic                 valid;
        logic [DATA_BITS-1:0] value;
        logic                 timed_out;
    } t_char_evt;

    // One result word
    typedef struct packed {
        logic [DATA_BITS-1:0] value;
        logic                 timed_out;
        logic                 line_end;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/ulr_frame.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ulr_frame (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic                       i_rx_bit,
    input  wire logic                       i_cfg_we,
    input  wire logic [ulr_pkg::IDLE_W-1:0] i_cfg_data,
    output ulr_pkg::t_char_evt              o_evt
);

    logic [ulr_pkg::IDLE_W-1:0]          r_max_idle_ticks;
    logic                                r_in_frame;
    logic [ulr_pkg::BIT_CNT_W-1:0]       r_bit_index;
    logic [ulr_pkg::IDLE_W-1:0]          r_idle_count;
    logic [ulr_pkg::DATA_BITS-1:0]       r_shift_byte;

    logic                                n_in_frame;
    logic [ulr_pkg::BIT_CNT_W-1:0]       n_bit_index;
    logic [ulr_pkg::IDLE_W-1:0]          n_idle_count;
    logic [ulr_pkg::IDLE_W-1:0]          idle_inc;
    logic [ulr_pkg::DATA_BITS-1:0]       n_shift_byte;
    ulr_pkg::t_char_evt                  evt;

    always_comb begin
        n_in_frame   = r_in_frame;
        n_bit_index  = r_bit_index;
        n_idle_count = r_idle_count;
        n_shift_byte = r_shift_byte;
        evt          = '0;
        idle_inc     = (r_idle_count != ulr_pkg::IDLE_MAX) ? r_idle_count + 1'b1
                                                           : r_idle_count;
        if (r_in_frame) begin
            n_idle_count = '0;
            if (r_bit_index < ulr_pkg::BIT_CNT_W'(ulr_pkg::DATA_BITS)) begin
                n_shift_byte[r_bit_index[ulr_pkg::BIT_IDX_W-1:0]] = i_rx_bit;
                n_bit_index = r_bit_index + 1'b1;
            end else begin
                // stop position: good stop emits, bad stop drops the byte
                n_bit_index  = '0;
                n_in_frame   = 1'b0;
                n_shift_byte = '0;
                evt.valid    = i_rx_bit;
                evt.value    = r_shift_byte;
            end
        end else begin
            n_idle_count = idle_inc;
            n_in_frame   = ~i_rx_bit;
            if (idle_inc > r_max_idle_ticks) begin
                n_idle_count  = '0;
                n_shift_byte  = '0;
                evt.valid     = 1'b1;
                evt.timed_out = 1'b1;
            end
        end
        if (!i_accept) begin
            evt.valid = 1'b0;
        end
    end

    assign o_evt = evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_idle_ticks <= ulr_pkg::MAX_IDLE_RESET;
            r_in_frame       <= 1'b0;
            r_bit_index      <= '0;
            r_idle_count     <= '0;
            r_shift_byte     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_idle_ticks <= i_cfg_data;
            end
            if (i_accept) begin
                r_in_frame   <= n_in_frame;
                r_bit_index  <= n_bit_index;
                r_idle_count <= n_idle_count;
                r_shift_byte <= n_shift_byte;
            end
        end
    end

`include "uart_line_receiver_unit_assert.svh"

    `ULR_ASSERT_NOW(a_bit_index_range,
        1'b1, r_bit_index <= ulr_pkg::BIT_CNT_W'(ulr_pkg::DATA_BITS),
        "bit index past stop position")
    `ULR_ASSERT_NOW(a_idle_index_zero,
        !r_in_frame, r_bit_index == '0,
        "bit index nonzero while idle")
    `ULR_ASSERT_NEXT(a_frame_clears_idle,
        i_accept && r_in_frame, r_idle_count == '0,
        "idle count not cleared by in-frame sample")

endmodule

`default_nettype wire

// ===== sv/ulr_line.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ulr_line (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire ulr_pkg::t_char_evt i_evt,
    output ulr_pkg::t_result o_result
);

    logic [ulr_pkg::LINE_POS_W-1:0] r_line_pos;
    logic [ulr_pkg::LINE_POS_W-1:0] pos_next;
    logic                           line_end;

    assign pos_next = r_line_pos + 1'b1;
    assign line_end = (i_evt.value == ulr_pkg::LINE_FEED)
                   || (pos_next >= ulr_pkg::LINE_POS_W'(ulr_pkg::LINE_BYTES));

    assign o_result.value     = i_evt.value;
    assign o_result.timed_out = i_evt.timed_out;
    assign o_result.line_end  = line_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pos <= '0;
        end else if (i_evt.valid) begin
            r_line_pos <= line_end ? '0 : pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ulr_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ulr_out_buf (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire ulr_pkg::t_result i_data,
    output logic             o_room,
    output logic             o_valid,
    input  wire logic        i_ready,
    output ulr_pkg::t_result o_data
);

    logic             r_out_valid;
    logic             r_skid_valid;
    ulr_pkg::t_result r_out;
    ulr_pkg::t_result r_skid;
    logic             pop;

    assign pop     = r_out_valid && i_ready;
    assign o_room  = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= i_push;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= i_data;
            end else begin
                r_out  <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

`include "uart_line_receiver_unit_assert.svh"

    `ULR_ASSERT_NOW(a_skid_behind_out,
        r_skid_valid, r_out_valid,
        "skid word held with empty output stage")
    `ULR_ASSERT_NOW(a_push_has_room,
        i_push, !r_skid_valid,
        "word pushed into full buffer")
    `ULR_ASSERT_NEXT(a_skid_refills_out,
        r_skid_valid && pop, r_out_valid,
        "skid word lost on output pop")

endmodule

`default_nettype wire

// ===== sv/uart_line_receiver_unit.sv =====
// UART line receiver, 8N1, with line framing.
//
// Input channel (i_rx_valid / o_rx_ready / i_rx_bit): one line sample per
// baud tick, accepted when valid and ready are both high.
// Output channel (o_char_valid / i_char_ready): one word per completed
// character or idle timeout, carrying o_char_value, o_timed_out, o_line_end.
// Config: i_cfg_we writes i_cfg_data into the idle limit (reset 9600).
// Write it only while the receiver is quiet.
//
// Throughput: one sample per cycle while o_rx_ready is high. Frame and line logic are a single
// combinational pass from the state registers into a two-word output buffer.
// Each completed word is registered into the output register, or into the skid
// register when the output register still holds an untaken word.
// Back-pressure: the output buffer has a main register and a skid register;
// o_rx_ready drops only once both hold untaken words, so a stalled sink
// stops sampling after two pending words and nothing is lost.
// Reset (i_rst_n low, synchronous): idle state, position zero, buffer empty,
// idle limit back to 9600.
`timescale 1ns / 1ps
`default_nettype none

module uart_line_receiver_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_rx_valid,
    output logic                               o_rx_ready,
    input  wire logic                          i_rx_bit,
    output logic                               o_char_valid,
    input  wire logic                          i_char_ready,
    output logic [ulr_pkg::DATA_BITS-1:0]      o_char_value,
    output logic                               o_timed_out,
    output logic                               o_line_end,
    input  wire logic                          i_cfg_we,
    input  wire logic [ulr_pkg::IDLE_W-1:0]    i_cfg_data
);

    logic               accept;
    logic               room;
    ulr_pkg::t_char_evt evt;
    ulr_pkg::t_result   result;
    ulr_pkg::t_result   out_word;

    assign o_rx_ready = room;
    assign accept     = i_rx_valid && room;

    // sample decode: start, data bits, stop, idle timeout
    ulr_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_rx_bit   (i_rx_bit),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_evt      (evt)
    );

    // line position and line-end flag
    ulr_line u_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_evt    (evt),
        .o_result (result)
    );

    // result register plus skid word
    ulr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (evt.valid),
        .i_data  (result),
        .o_room  (room),
        .o_valid (o_char_valid),
        .i_ready (i_char_ready),
        .o_data  (out_word)
    );

    assign o_char_value = out_word.value;
    assign o_timed_out  = out_word.timed_out;
    assign o_line_end   = out_word.line_end;

endmodule

`default_nettype wire
